[src/lorp_pkg.sv]
`default_nettype none

package lorp_pkg;

    // default sizes of the storage
    localparam int MAX_SLOTS_DEF  = 64;
    localparam int MAX_OWNERS_DEF = 256;

    // field widths of the ports
    localparam int FUNC_W      = 2;
    localparam int OWNER_ID_W  = 9;
    localparam int RES_ID_W    = 6;
    localparam int EVICT_W     = 8;
    localparam int MODE_W      = 2;
    localparam int POOL_W      = 7;
    localparam int OWNERS_W    = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWNER_COUNT  = 2'd2;

    // configuration reset values
    localparam logic [MODE_W-1:0]   RELEASE_MODE_RST = 2'd0;
    localparam logic [POOL_W-1:0]   POOL_SIZE_RST    = 7'd64;
    localparam logic [OWNERS_W-1:0] OWNER_COUNT_RST  = 9'd256;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_GRAB    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;

    // release modes
    localparam logic [MODE_W-1:0] REL_KEEP = 2'd0;
    localparam logic [MODE_W-1:0] REL_HEAD = 2'd1;
    localparam logic [MODE_W-1:0] REL_TAIL = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [OWNER_ID_W-1:0] owner_id;
    } item_t;

    typedef struct packed {
        logic                  status;
        logic                  has_resource;
        logic [RES_ID_W-1:0]   resource_id;
        logic                  got_new;
        logic                  evicted_valid;
        logic [EVICT_W-1:0]    evicted_owner;
    } result_t;

endpackage

`default_nettype wire

[src/lru_owner_resource_pool_top.sv]
`default_nettype none

// LRU resource pool: slots sit in a recency list (head = least recently used,
// tail = most recently used), kept as prev/next link memories, with an owner
// table and a slot table in memories beside them. One item is worked at a time
// by a small sequencer that makes one read and at most one write per memory
// each cycle: a query or a release without a move goes from the owner look-up
// straight to the result, a move adds the unlink and link steps, and a grab
// that binds a new slot first reads and rebinds the head slot. An
// out-of-range owner skips the look-up, and a move is skipped when the slot
// already sits at that end (as for a one-slot pool). A result that is still
// waiting on result_ready holds the next result back in the done state.
// Writing pool_size or owner_count, and reset, starts a clearing pass over
// max(MAX_OWNERS, MAX_SLOTS) table entries during which no item is
// accepted; configuration writes are always accepted and should be made only
// while the block is idle.
module lru_owner_resource_pool_top
    import lorp_pkg::*;
#(
    parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
    parameter int MAX_OWNERS = MAX_OWNERS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire item_t                 item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output result_t                    result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int OWN_W  = $clog2(MAX_OWNERS);
    localparam int LINK_W = SLOT_W + 1;
    localparam int CLR_N  = (MAX_OWNERS > MAX_SLOTS) ? MAX_OWNERS : MAX_SLOTS;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int PC_W   = (SLOT_W + 1 > POOL_W) ? SLOT_W + 1 : POOL_W;
    localparam int OC_W   = (OWN_W + 1 > OWNERS_W) ? OWN_W + 1 : OWNERS_W;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_SLOTS);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_OS,
        ST_GRAB_SO,
        ST_GRAB_WR,
        ST_MV_UNLINK,
        ST_MV_LINK1,
        ST_MV_LINK2,
        ST_DONE
    } state_t;

    // control and config registers
    state_t                state_reg, state_next;
    logic [CLR_W-1:0]      clr_reg, clr_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [POOL_W-1:0]     pool_reg, pool_next;
    logic [OWNERS_W-1:0]   owners_reg, owners_next;
    logic [LINK_W-1:0]     head_reg, head_next;
    logic [LINK_W-1:0]     tail_reg, tail_next;
    logic                  result_valid_reg, result_valid_next;

    // item work registers
    logic [FUNC_W-1:0]     func_reg, func_next;
    logic [OWN_W-1:0]      own_reg, own_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic                  to_tail_reg, to_tail_next;
    logic                  status_reg, status_next;
    logic                  has_reg, has_next;
    logic                  got_reg, got_next;
    logic                  evv_reg, evv_next;
    logic [OWN_W-1:0]      evo_reg, evo_next;
    result_t               result_reg, result_next;

    // memories: owner table {valid, slot}, slot table {valid, owner}, links
    logic [SLOT_W:0]       owner_slot_mem [MAX_OWNERS];
    logic [OWN_W:0]        slot_owner_mem [MAX_SLOTS];
    logic [LINK_W-1:0]     next_link_mem  [MAX_SLOTS];
    logic [LINK_W-1:0]     prev_link_mem  [MAX_SLOTS];

    logic                  os_we;
    logic [OWN_W-1:0]      os_wa, os_ra;
    logic [SLOT_W:0]       os_wd, os_rdata_reg;
    logic                  so_we;
    logic [SLOT_W-1:0]     so_wa, so_ra;
    logic [OWN_W:0]        so_wd, so_rdata_reg;
    logic                  nx_we;
    logic [SLOT_W-1:0]     nx_wa, link_ra;
    logic [LINK_W-1:0]     nx_wd, nx_rdata_reg;
    logic                  pv_we;
    logic [SLOT_W-1:0]     pv_wa;
    logic [LINK_W-1:0]     pv_wd, pv_rdata_reg;

    // helpers
    logic [OWN_W-1:0]      own_idx;
    logic                  own_ok;
    logic [OC_W-1:0]       owners_eff;
    logic [PC_W-1:0]       pool_eff;
    logic [SLOT_W-1:0]     clr_slot;
    logic [PC_W-1:0]       clr_slot_ext;
    logic                  clr_in_owners;
    logic                  clr_in_slots;
    logic                  mv_go;
    logic                  mv_tail;
    logic [SLOT_W-1:0]     mv_slot;

    assign item_ready   = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // effective sizes and owner range check
    assign owners_eff = (OC_W'(owners_reg) > OC_W'(MAX_OWNERS)) ? OC_W'(MAX_OWNERS)
                                                                : OC_W'(owners_reg);
    assign pool_eff   = (PC_W'(pool_reg) > PC_W'(MAX_SLOTS)) ? PC_W'(MAX_SLOTS)
                                                             : PC_W'(pool_reg);
    assign own_idx    = OWN_W'(item.owner_id);
    assign own_ok     = (OC_W'(item.owner_id) < owners_eff);

    // clearing pass position
    assign clr_slot      = clr_reg[SLOT_W-1:0];
    assign clr_slot_ext  = PC_W'(clr_slot);
    assign clr_in_owners = ({1'b0, clr_reg} < (CLR_W + 1)'(MAX_OWNERS));
    assign clr_in_slots  = ({1'b0, clr_reg} < (CLR_W + 1)'(MAX_SLOTS));

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        mode_next         = mode_reg;
        pool_next         = pool_reg;
        owners_next       = owners_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        func_next         = func_reg;
        own_next          = own_reg;
        slot_next         = slot_reg;
        to_tail_next      = to_tail_reg;
        status_next       = status_reg;
        has_next          = has_reg;
        got_next          = got_reg;
        evv_next          = evv_reg;
        evo_next          = evo_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;

        os_we   = 1'b0;
        os_wa   = own_reg;
        os_wd   = '0;
        os_ra   = own_idx;
        so_we   = 1'b0;
        so_wa   = slot_reg;
        so_wd   = '0;
        so_ra   = head_reg[SLOT_W-1:0];
        nx_we   = 1'b0;
        nx_wa   = slot_reg;
        nx_wd   = NIL;
        pv_we   = 1'b0;
        pv_wa   = slot_reg;
        pv_wd   = NIL;

        mv_go   = 1'b0;
        mv_tail = 1'b1;
        mv_slot = slot_reg;

        case (state_reg)
            // sweep all tables back to their initial contents
            ST_CLEAR:
            begin
                os_we = clr_in_owners;
                os_wa = clr_reg[OWN_W-1:0];
                os_wd = '0;
                so_we = clr_in_slots;
                so_wa = clr_slot;
                so_wd = '0;
                nx_we = clr_in_slots;
                nx_wa = clr_slot;
                nx_wd = (clr_slot == '0 || clr_slot_ext >= pool_eff)
                        ? NIL : {1'b0, clr_slot - 1'b1};
                pv_we = clr_in_slots;
                pv_wa = clr_slot;
                pv_wd = (clr_slot_ext + PC_W'(1) >= pool_eff)
                        ? NIL : LINK_W'(clr_slot_ext + PC_W'(1));
                if (clr_reg == CLR_W'(CLR_N - 1))
                begin
                    head_next  = (pool_eff == '0) ? NIL : LINK_W'(pool_eff - PC_W'(1));
                    tail_next  = (pool_eff == '0) ? NIL : '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            // take a transaction and look up the owner
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    func_next   = item.func;
                    own_next    = own_idx;
                    status_next = !own_ok;
                    has_next    = 1'b0;
                    got_next    = 1'b0;
                    evv_next    = 1'b0;
                    evo_next    = '0;
                    state_next  = own_ok ? ST_RD_OS : ST_DONE;
                end
            end

            // owner entry is back
            ST_RD_OS:
            begin
                case (func_reg)
                    FUNC_GRAB:
                    begin
                        if (os_rdata_reg[SLOT_W])
                        begin
                            has_next = 1'b1;
                            mv_go    = 1'b1;
                            mv_tail  = 1'b1;
                            mv_slot  = os_rdata_reg[SLOT_W-1:0];
                        end
                        else if (head_reg == NIL)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            slot_next  = head_reg[SLOT_W-1:0];
                            state_next = ST_GRAB_SO;
                        end
                    end
                    FUNC_RELEASE:
                    begin
                        if (os_rdata_reg[SLOT_W])
                        begin
                            os_we   = 1'b1;
                            os_wa   = own_reg;
                            os_wd   = '0;
                            so_we   = 1'b1;
                            so_wa   = os_rdata_reg[SLOT_W-1:0];
                            so_wd   = '0;
                            mv_slot = os_rdata_reg[SLOT_W-1:0];
                            if (mode_reg == REL_HEAD)
                            begin
                                mv_go   = 1'b1;
                                mv_tail = 1'b0;
                            end
                            else if (mode_reg == REL_TAIL)
                            begin
                                mv_go   = 1'b1;
                                mv_tail = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        has_next   = os_rdata_reg[SLOT_W];
                        slot_next  = os_rdata_reg[SLOT_W-1:0];
                        state_next = ST_DONE;
                    end
                endcase
            end

            // head slot owner is back: evict and bind the slot
            ST_GRAB_SO:
            begin
                if (so_rdata_reg[OWN_W])
                begin
                    os_we    = 1'b1;
                    os_wa    = so_rdata_reg[OWN_W-1:0];
                    os_wd    = '0;
                    evv_next = 1'b1;
                    evo_next = so_rdata_reg[OWN_W-1:0];
                end
                so_we      = 1'b1;
                so_wa      = slot_reg;
                so_wd      = {1'b1, own_reg};
                got_next   = 1'b1;
                has_next   = 1'b1;
                state_next = ST_GRAB_WR;
            end

            // bind the owner to the slot, then move it to the tail
            ST_GRAB_WR:
            begin
                os_we   = 1'b1;
                os_wa   = own_reg;
                os_wd   = {1'b1, slot_reg};
                mv_go   = 1'b1;
                mv_tail = 1'b1;
                mv_slot = slot_reg;
            end

            // take the slot out of the list
            ST_MV_UNLINK:
            begin
                if (nx_rdata_reg != NIL)
                begin
                    pv_we = 1'b1;
                    pv_wa = nx_rdata_reg[SLOT_W-1:0];
                    pv_wd = pv_rdata_reg;
                end
                else
                begin
                    tail_next = pv_rdata_reg;
                end
                if (pv_rdata_reg != NIL)
                begin
                    nx_we = 1'b1;
                    nx_wa = pv_rdata_reg[SLOT_W-1:0];
                    nx_wd = nx_rdata_reg;
                end
                else
                begin
                    head_next = nx_rdata_reg;
                end
                state_next = ST_MV_LINK1;
            end

            // set the moved slot's own links
            ST_MV_LINK1:
            begin
                nx_we = 1'b1;
                nx_wa = slot_reg;
                pv_we = 1'b1;
                pv_wa = slot_reg;
                if (to_tail_reg)
                begin
                    pv_wd = tail_reg;
                    nx_wd = NIL;
                end
                else
                begin
                    nx_wd = head_reg;
                    pv_wd = NIL;
                end
                state_next = ST_MV_LINK2;
            end

            // hook the neighbor at the list end to the moved slot
            ST_MV_LINK2:
            begin
                if (to_tail_reg)
                begin
                    if (tail_reg != NIL)
                    begin
                        nx_we = 1'b1;
                        nx_wa = tail_reg[SLOT_W-1:0];
                        nx_wd = {1'b0, slot_reg};
                    end
                    else
                    begin
                        head_next = {1'b0, slot_reg};
                    end
                    tail_next = {1'b0, slot_reg};
                end
                else
                begin
                    if (head_reg != NIL)
                    begin
                        pv_we = 1'b1;
                        pv_wa = head_reg[SLOT_W-1:0];
                        pv_wd = {1'b0, slot_reg};
                    end
                    else
                    begin
                        tail_next = {1'b0, slot_reg};
                    end
                    head_next = {1'b0, slot_reg};
                end
                state_next = ST_DONE;
            end

            // hand the result to the output register once it is free
            ST_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.status        = status_reg;
                    result_next.has_resource  = has_reg;
                    result_next.resource_id   = has_reg ? RES_ID_W'(slot_reg) : '0;
                    result_next.got_new       = got_reg;
                    result_next.evicted_valid = evv_reg;
                    result_next.evicted_owner = evv_reg ? EVICT_W'(evo_reg) : '0;
                    result_valid_next         = 1'b1;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // start of a move: skip when the slot already sits at that end
        if (mv_go)
        begin
            slot_next    = mv_slot;
            to_tail_next = mv_tail;
            if ((mv_tail && tail_reg == {1'b0, mv_slot}) ||
                (!mv_tail && head_reg == {1'b0, mv_slot}))
            begin
                state_next = ST_DONE;
            end
            else
            begin
                state_next = ST_MV_UNLINK;
            end
        end
        link_ra = mv_slot;

        // configuration writes; a size write restarts the clearing pass
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RELEASE_MODE:
                begin
                    mode_next = cfg_data[MODE_W-1:0];
                end
                CFG_POOL_SIZE:
                begin
                    pool_next  = cfg_data[POOL_W-1:0];
                    state_next = ST_CLEAR;
                    clr_next   = '0;
                end
                CFG_OWNER_COUNT:
                begin
                    owners_next = cfg_data[OWNERS_W-1:0];
                    state_next  = ST_CLEAR;
                    clr_next    = '0;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            mode_reg         <= RELEASE_MODE_RST;
            pool_reg         <= POOL_SIZE_RST;
            owners_reg       <= OWNER_COUNT_RST;
            head_reg         <= NIL;
            tail_reg         <= NIL;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            mode_reg         <= mode_next;
            pool_reg         <= pool_next;
            owners_reg       <= owners_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // item payload registers
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        own_reg     <= own_next;
        slot_reg    <= slot_next;
        to_tail_reg <= to_tail_next;
        status_reg  <= status_next;
        has_reg     <= has_next;
        got_reg     <= got_next;
        evv_reg     <= evv_next;
        evo_reg     <= evo_next;
        result_reg  <= result_next;
    end

    // owner table
    always_ff @(posedge clk)
    begin
        if (os_we)
        begin
            owner_slot_mem[os_wa] <= os_wd;
        end
        os_rdata_reg <= owner_slot_mem[os_ra];
    end

    // slot table
    always_ff @(posedge clk)
    begin
        if (so_we)
        begin
            slot_owner_mem[so_wa] <= so_wd;
        end
        so_rdata_reg <= slot_owner_mem[so_ra];
    end

    // next links
    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_link_mem[nx_wa] <= nx_wd;
        end
        nx_rdata_reg <= next_link_mem[link_ra];
    end

    // prev links
    always_ff @(posedge clk)
    begin
        if (pv_we)
        begin
            prev_link_mem[pv_wa] <= pv_wd;
        end
        pv_rdata_reg <= prev_link_mem[link_ra];
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
    import lorp_pkg::*;

    localparam int SLOTS  = MAX_SLOTS_DEF;
    localparam int OWNERS = MAX_OWNERS_DEF;
    localparam int SLOT_IW = $clog2(SLOTS);
    localparam logic [6:0] NO_SLOT = 7'(SLOTS);

    // codes that the package leaves unnamed
    localparam logic [FUNC_W-1:0]    FUNC_SPARE = 2'd3;
    localparam logic [MODE_W-1:0]    REL_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_OWNER = 1'b1;

    localparam int SETTLE_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 128;
    localparam int EMPTY_POOL_ITEMS = 40;
    localparam int REPORT_MAX      = 10;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        item_t                 it;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        bit                    known;
        result_t               want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_ready;
    item_t                 item = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // typed expectation that rides along with the item on the wire
    bit      row_known = 1'b0;
    result_t row_want = '0;
    bit      quiet_run = 1'b0;

    result_t   pending_results [$];
    stim_row_t directed_rows [$];
    int        error_count = 0;
    int        idle_cycles = 0;

    // pool state as predicted
    logic [MODE_W-1:0]   rel_mode_q;
    logic [POOL_W-1:0]   pool_size_q;
    logic [OWNERS_W-1:0] owner_count_q;
    logic [6:0]          owner_slot_tbl [OWNERS];   // slot + 1, zero when none
    logic [8:0]          slot_owner_tbl [SLOTS];    // owner + 1, zero when free
    logic [6:0]          link_next [SLOTS];
    logic [6:0]          link_prev [SLOTS];
    logic [6:0]          lru_head;
    logic [6:0]          mru_tail;

    lru_owner_resource_pool_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int live_slots();
        return (pool_size_q > SLOTS) ? SLOTS : int'(pool_size_q);
    endfunction

    function automatic int live_owners();
        return (owner_count_q > OWNERS) ? OWNERS : int'(owner_count_q);
    endfunction

    // empty tables, recency chain from the top slot down to slot zero
    function automatic void pool_clear();
        int n;
        n = live_slots();
        for (int i = 0; i < OWNERS; i++)
            owner_slot_tbl[i] = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_owner_tbl[i] = '0;
            link_next[i] = NO_SLOT;
            link_prev[i] = NO_SLOT;
            if (i > 0 && i < n)
                link_next[i] = 7'(i - 1);
            if (i + 1 < n)
                link_prev[i] = 7'(i + 1);
        end
        lru_head = (n == 0) ? NO_SLOT : 7'(n - 1);
        mru_tail = (n == 0) ? NO_SLOT : 7'd0;
    endfunction

    function automatic void chain_unlink(logic [6:0] s);
        logic [6:0] p;
        logic [6:0] nx;
        p  = link_prev[s[SLOT_IW-1:0]];
        nx = link_next[s[SLOT_IW-1:0]];
        if (p != NO_SLOT)
            link_next[p[SLOT_IW-1:0]] = nx;
        else
            lru_head = nx;
        if (nx != NO_SLOT)
            link_prev[nx[SLOT_IW-1:0]] = p;
        else
            mru_tail = p;
    endfunction

    function automatic void chain_to_tail(logic [6:0] s);
        if (s == mru_tail)
            return;
        chain_unlink(s);
        link_prev[s[SLOT_IW-1:0]] = mru_tail;
        link_next[s[SLOT_IW-1:0]] = NO_SLOT;
        if (mru_tail != NO_SLOT)
            link_next[mru_tail[SLOT_IW-1:0]] = s;
        else
            lru_head = s;
        mru_tail = s;
    endfunction

    function automatic void chain_to_head(logic [6:0] s);
        if (s == lru_head)
            return;
        chain_unlink(s);
        link_next[s[SLOT_IW-1:0]] = lru_head;
        link_prev[s[SLOT_IW-1:0]] = NO_SLOT;
        if (lru_head != NO_SLOT)
            link_prev[lru_head[SLOT_IW-1:0]] = s;
        else
            mru_tail = s;
        lru_head = s;
    endfunction

    function automatic void pool_write_reg(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_RELEASE_MODE: rel_mode_q = val[MODE_W-1:0];
            CFG_POOL_SIZE:
            begin
                pool_size_q = val[POOL_W-1:0];
                pool_clear();
            end
            CFG_OWNER_COUNT:
            begin
                owner_count_q = val[OWNERS_W-1:0];
                pool_clear();
            end
            default: ;
        endcase
    endfunction

    // apply one transaction to the pool and return what the block should answer
    function automatic result_t pool_apply(item_t it);
        result_t    r;
        logic [7:0] o;
        logic [6:0] s;
        logic [8:0] prior;
        r = '0;
        if (it.owner_id >= live_owners())
        begin
            r.status = STATUS_BAD_OWNER;
            return r;
        end
        o = it.owner_id[7:0];
        case (it.func)
            FUNC_GRAB:
            begin
                // bind the least recently used slot, taking it from its holder
                if (owner_slot_tbl[o] == '0 && lru_head != NO_SLOT)
                begin
                    s = lru_head;
                    prior = slot_owner_tbl[s[SLOT_IW-1:0]];
                    if (prior != '0)
                    begin
                        owner_slot_tbl[8'(prior - 1)] = '0;
                        r.evicted_valid = 1'b1;
                        r.evicted_owner = 8'(prior - 1);
                    end
                    owner_slot_tbl[o] = s + 1;
                    slot_owner_tbl[s[SLOT_IW-1:0]] = o + 1;
                    r.got_new = 1'b1;
                end
                if (owner_slot_tbl[o] != '0)
                begin
                    s = owner_slot_tbl[o] - 1;
                    chain_to_tail(s);
                    r.has_resource = 1'b1;
                    r.resource_id = s[RES_ID_W-1:0];
                end
            end
            FUNC_RELEASE:
            begin
                if (owner_slot_tbl[o] != '0)
                begin
                    s = owner_slot_tbl[o] - 1;
                    owner_slot_tbl[o] = '0;
                    slot_owner_tbl[s[SLOT_IW-1:0]] = '0;
                    if (rel_mode_q == REL_HEAD)
                        chain_to_head(s);
                    else if (rel_mode_q == REL_TAIL)
                        chain_to_tail(s);
                end
            end
            default:
            begin
                // query, and the spare func code acts the same
                if (owner_slot_tbl[o] != '0)
                begin
                    s = owner_slot_tbl[o] - 1;
                    r.has_resource = 1'b1;
                    r.resource_id = s[RES_ID_W-1:0];
                end
            end
        endcase
        return r;
    endfunction

    function automatic result_t outcome(logic st, logic has, int rid, logic got,
                                        logic evv, int evo);
        result_t r;
        r.status        = st;
        r.has_resource  = has;
        r.resource_id   = rid[RES_ID_W-1:0];
        r.got_new       = got;
        r.evicted_valid = evv;
        r.evicted_owner = evo[EVICT_W-1:0];
        return r;
    endfunction

    function automatic string describe(result_t r);
        return $sformatf("status=%0d has=%0d id=%0d new=%0d evicted=%0d owner=%0d",
                         r.status, r.has_resource, r.resource_id, r.got_new,
                         r.evicted_valid, r.evicted_owner);
    endfunction

    function automatic void add_item(logic [FUNC_W-1:0] f, int o);
        stim_row_t r;
        r.kind = ROW_ITEM;
        r.it.func = f;
        r.it.owner_id = o[OWNER_ID_W-1:0];
        r.reg_idx = '0;
        r.reg_val = '0;
        r.known = 1'b0;
        r.want = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_check(logic [FUNC_W-1:0] f, int o, result_t want);
        add_item(f, o);
        directed_rows[$].known = 1'b1;
        directed_rows[$].want = want;
    endfunction

    function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, int val);
        stim_row_t r;
        r.kind = ROW_REG;
        r.it = '0;
        r.reg_idx = idx;
        r.reg_val = val[CFG_DATA_W-1:0];
        r.known = 1'b0;
        r.want = '0;
        directed_rows.push_back(r);
    endfunction

    // one item transaction, with a random gap ahead of it
    task automatic drive_item(item_t it, bit known, result_t want);
        int gap;
        gap = quiet_run ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item = it;
        row_known = known;
        row_want = want;
        item_valid = 1'b1;
        do @(posedge clk); while (!item_ready);
    endtask

    // hold off the sender until every answer is back
    task automatic wait_drained(int extra);
        @(negedge clk);
        item_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained(SETTLE_CYCLES);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // result side stalls at random
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = quiet_run ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                result_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready = 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    // predict on accepted items, check accepted results, watch for a hang
    always @(posedge clk)
    begin : watch_ports
        logic    moved;
        result_t want;
        moved = 1'b0;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            pool_write_reg(cfg_index, cfg_data);
            moved = 1'b1;
        end
        if (rst_n && item_valid && item_ready)
        begin
            want = pool_apply(item);
            if (row_known)
                want = row_want;
            pending_results.push_back(want);
            moved = 1'b1;
        end
        if (rst_n && result_valid && result_ready)
        begin
            moved = 1'b1;
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("result transaction with none expected: %s", describe(result));
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status
                    || result.has_resource !== want.has_resource
                    || result.resource_id !== want.resource_id
                    || result.got_new !== want.got_new
                    || result.evicted_valid !== want.evicted_valid
                    || result.evicted_owner !== want.evicted_owner)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("mismatch: expected %s, got %s",
                                 describe(want), describe(result));
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        item_t                 it;
        logic [MODE_W-1:0]     mode;
        logic [CFG_DATA_W-1:0] psz;
        logic [CFG_DATA_W-1:0] ocnt;
        int                    n;
        int                    span;
        int                    own_lim;
        int                    sel;

        rel_mode_q = RELEASE_MODE_RST;
        pool_size_q = POOL_SIZE_RST;
        owner_count_q = OWNER_COUNT_RST;
        pool_clear();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults after reset: slot 63 is least recently used
        add_check(FUNC_QUERY, 0, outcome(STATUS_OK, 0, 0, 0, 0, 0));
        add_check(FUNC_GRAB, 0, outcome(STATUS_OK, 1, 63, 1, 0, 0));
        add_check(FUNC_GRAB, 255, outcome(STATUS_OK, 1, 62, 1, 0, 0));
        add_check(FUNC_GRAB, 0, outcome(STATUS_OK, 1, 63, 0, 0, 0));
        // owner numbers past the count
        add_check(FUNC_GRAB, 256, outcome(STATUS_BAD_OWNER, 0, 0, 0, 0, 0));
        add_check(FUNC_RELEASE, 511, outcome(STATUS_BAD_OWNER, 0, 0, 0, 0, 0));
        // release with nothing held, spare func code as a query
        add_check(FUNC_RELEASE, 7, outcome(STATUS_OK, 0, 0, 0, 0, 0));
        add_check(FUNC_SPARE, 255, outcome(STATUS_OK, 1, 62, 0, 0, 0));
        add_item(FUNC_RELEASE, 255);
        // two slots, third owner evicts the first
        add_reg(CFG_RELEASE_MODE, int'(REL_HEAD));
        add_reg(CFG_POOL_SIZE, 2);
        add_check(FUNC_GRAB, 1, outcome(STATUS_OK, 1, 1, 1, 0, 0));
        add_check(FUNC_GRAB, 2, outcome(STATUS_OK, 1, 0, 1, 0, 0));
        add_check(FUNC_GRAB, 3, outcome(STATUS_OK, 1, 1, 1, 1, 1));
        add_item(FUNC_RELEASE, 2);
        add_item(FUNC_GRAB, 1);
        add_reg(CFG_RELEASE_MODE, int'(REL_TAIL));
        add_item(FUNC_RELEASE, 3);
        add_item(FUNC_GRAB, 2);
        // spare release mode keeps the slot in place
        add_reg(CFG_RELEASE_MODE, int'(REL_SPARE));
        add_item(FUNC_RELEASE, 1);
        // write to an index with no register behind it
        add_reg(CFG_SPARE, 9'h1FF);
        add_item(FUNC_QUERY, 1);
        // empty pool
        add_reg(CFG_POOL_SIZE, 0);
        add_check(FUNC_GRAB, 4, outcome(STATUS_OK, 0, 0, 0, 0, 0));
        // zero owners
        add_reg(CFG_OWNER_COUNT, 0);
        add_check(FUNC_QUERY, 0, outcome(STATUS_BAD_OWNER, 0, 0, 0, 0, 0));
        // oversized sizes clamp to the storage
        add_reg(CFG_POOL_SIZE, 127);
        add_reg(CFG_OWNER_COUNT, 511);
        add_check(FUNC_GRAB, 255, outcome(STATUS_OK, 1, 63, 1, 0, 0));
        add_check(FUNC_GRAB, 256, outcome(STATUS_BAD_OWNER, 0, 0, 0, 0, 0));
        // single owner
        add_reg(CFG_OWNER_COUNT, 1);
        add_check(FUNC_GRAB, 0, outcome(STATUS_OK, 1, 63, 1, 0, 0));
        add_check(FUNC_QUERY, 1, outcome(STATUS_BAD_OWNER, 0, 0, 0, 0, 0));

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_REG)
                write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
            else
                drive_item(directed_rows[k].it, directed_rows[k].known,
                           directed_rows[k].want);
        end

        // random phases, the first ones pinned to the extremes
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    mode = REL_KEEP; psz = 64; ocnt = 256;
                end
                1:
                begin
                    mode = REL_HEAD; psz = 1; ocnt = 4;
                end
                2:
                begin
                    mode = REL_TAIL; psz = 4; ocnt = 9;
                end
                3:
                begin
                    mode = REL_SPARE; psz = 8; ocnt = 20;
                end
                4:
                begin
                    mode = REL_HEAD; psz = 127; ocnt = 511;
                end
                5:
                begin
                    mode = REL_TAIL; psz = 64; ocnt = 100;
                end
                6:
                begin
                    mode = REL_KEEP; psz = 0; ocnt = 3;
                end
                default:
                begin
                    mode = MODE_W'($urandom_range(0, 3));
                    psz = ($urandom_range(0, 3) == 0)
                          ? CFG_DATA_W'($urandom_range(0, 127))
                          : CFG_DATA_W'($urandom_range(1, 12));
                    ocnt = ($urandom_range(0, 3) == 0)
                           ? CFG_DATA_W'($urandom_range(0, 511))
                           : CFG_DATA_W'($urandom_range(1, 40));
                end
            endcase
            write_reg(CFG_RELEASE_MODE, CFG_DATA_W'(mode));
            write_reg(CFG_POOL_SIZE, psz);
            write_reg(CFG_OWNER_COUNT, ocnt);

            // owners drawn from a range a bit over twice the pool, so slots churn
            own_lim = live_owners();
            span = (own_lim < 2 * live_slots() + 3) ? own_lim : 2 * live_slots() + 3;
            n = (ph == 6) ? EMPTY_POOL_ITEMS : ITEMS_PER_PHASE;
            for (int k = 0; k < n; k++)
            begin
                if (k % 32 == 0)
                    quiet_run = ($urandom_range(0, 3) == 0);
                if (k == n / 2)
                    wait_drained(0);
                sel = $urandom_range(0, 19);
                if (sel < 9)
                    it.func = FUNC_GRAB;
                else if (sel < 13)
                    it.func = FUNC_RELEASE;
                else if (sel < 18)
                    it.func = FUNC_QUERY;
                else
                    it.func = FUNC_SPARE;
                sel = $urandom_range(0, 19);
                if (span > 0 && sel < 17)
                    it.owner_id = OWNER_ID_W'($urandom_range(0, span - 1));
                else if (sel < 19)
                    it.owner_id = OWNER_ID_W'($urandom_range(own_lim, 511));
                else
                    it.owner_id = OWNER_ID_W'($urandom_range(0, 511));
                drive_item(it, 1'b0, '0);
            end
        end

        wait_drained(SETTLE_CYCLES);
        if (error_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
src/lorp_pkg.sv
src/lru_owner_resource_pool_top.sv
tb/testbench.sv
